[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the address parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dipv4_pkg.sv]
// ----------------------------------------------------------------------------
// dipv4_pkg
// Shared widths, character codes and the token type of the address parser.
// ----------------------------------------------------------------------------
package dipv4_pkg;

    // Field widths
    localparam int CH_W   = 8;
    localparam int ADDR_W = 32;

    // Default depth of the token queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Character codes
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;

    // Class of one input byte
    typedef enum logic [2:0] {
        TOK_END,
        TOK_DOT,
        TOK_X,
        TOK_DIGIT,
        TOK_LETTER,
        TOK_BAD
    } tok_kind_t;

    // One classified byte: its class and, for digits and letters, its value
    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] value;
    } token_t;

    // Fill status of the token queue
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

[hdl/dipv4_ifs.sv]
// ----------------------------------------------------------------------------
// dipv4 channel interfaces
// Valid/ready channels for the incoming text bytes and the parse results.
// ----------------------------------------------------------------------------

// Text byte channel
interface dipv4_char_if;
    logic                       valid;
    logic                       ready;
    logic [dipv4_pkg::CH_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

// Parse result channel
interface dipv4_result_if;
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic [dipv4_pkg::ADDR_W-1:0] addr;

    modport source (output valid, output ok, output addr, input ready);
    modport sink   (input valid, input ok, input addr, output ready);
endinterface

[hdl/dotted_ipv4_text_parser_top.sv]
// ----------------------------------------------------------------------------
// dotted_ipv4_text_parser_top
// Parses a dotted IPv4 address string into a 32-bit address.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while the queue has room and gives
// one result on the result channel for each zero byte, which ends a string.
// The front classifies each byte, a token queue of QUEUE_DEPTH entries holds
// it, and the back applies it to the part being parsed, a shift-and-add by the
// part's base followed by a 36-bit overflow compare. A zero byte leaves the
// queue only when the single result register is free, so a stalled sink holds
// back the back end while the front keeps taking bytes until the queue is
// full. The result appears on the cycle after its zero byte leaves the queue.
`include "assert_macros.svh"

module dotted_ipv4_text_parser_top #(
    parameter int QUEUE_DEPTH = dipv4_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    dipv4_char_if.sink      text,
    dipv4_result_if.source  result
);

    logic                  push;
    logic                  pop;
    dipv4_pkg::token_t     wr_token;
    dipv4_pkg::token_t     head;
    dipv4_pkg::q_status_t  q_status;

    // Byte classification
    dipv4_front u_front (
        .text     (text),
        .q_status (q_status),
        .push     (push),
        .token    (wr_token)
    );

    // Token queue
    dipv4_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_token (wr_token),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // Part parser and result register
    dipv4_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .result   (result)
    );

    // Checks
    `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, q_status.empty, !pop, "pop from empty queue")
    `ASSERT_IMPLIES(a_full_stalls, clk, rst_n, q_status.full, !text.ready, "take while full")
    `ASSERT_NEXT(a_end_gives_result, clk, rst_n, pop && head.kind == dipv4_pkg::TOK_END, result.valid, "end byte without result")
    `ASSERT_IMPLIES(a_bad_addr_zero, clk, rst_n, result.valid && !result.ok, result.addr == '0, "failed parse with address")

endmodule

[hdl/dipv4_front.sv]
// ----------------------------------------------------------------------------
// dipv4_front
// Accepts text bytes and classifies each one into a token for the queue.
// ----------------------------------------------------------------------------
module dipv4_front (
    dipv4_char_if.sink          text,
    input  dipv4_pkg::q_status_t q_status,
    output logic                 push,
    output dipv4_pkg::token_t    token
);

    // A byte is taken whenever the queue has room.
    assign text.ready = !q_status.full;
    assign push       = text.valid && !q_status.full;

    // Classify the byte.
    always_comb
    begin
        token.kind  = dipv4_pkg::TOK_BAD;
        token.value = 4'd0;
        if (text.ch == dipv4_pkg::CH_NUL)
        begin
            token.kind = dipv4_pkg::TOK_END;
        end
        else if (text.ch == dipv4_pkg::CH_DOT)
        begin
            token.kind = dipv4_pkg::TOK_DOT;
        end
        else if (text.ch == dipv4_pkg::CH_LO_X || text.ch == dipv4_pkg::CH_UP_X)
        begin
            token.kind = dipv4_pkg::TOK_X;
        end
        else if (text.ch >= dipv4_pkg::CH_ZERO && text.ch <= dipv4_pkg::CH_NINE)
        begin
            token.kind  = dipv4_pkg::TOK_DIGIT;
            token.value = 4'(text.ch - dipv4_pkg::CH_ZERO);
        end
        else if (text.ch >= dipv4_pkg::CH_LO_A && text.ch <= dipv4_pkg::CH_LO_F)
        begin
            token.kind  = dipv4_pkg::TOK_LETTER;
            token.value = 4'(text.ch - dipv4_pkg::CH_LO_A + 8'd10);
        end
        else if (text.ch >= dipv4_pkg::CH_UP_A && text.ch <= dipv4_pkg::CH_UP_F)
        begin
            token.kind  = dipv4_pkg::TOK_LETTER;
            token.value = 4'(text.ch - dipv4_pkg::CH_UP_A + 8'd10);
        end
    end

endmodule

[hdl/dipv4_queue.sv]
// ----------------------------------------------------------------------------
// dipv4_queue
// Short token queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
module dipv4_queue #(
    parameter int DEPTH = dipv4_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  dipv4_pkg::token_t     wr_token,
    input  logic                  pop,
    output dipv4_pkg::token_t     head,
    output dipv4_pkg::q_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dipv4_pkg::token_t entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // Status and head of the queue
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign head         = entries_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Token storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= wr_token;
        end
    end

endmodule

[hdl/dipv4_back.sv]
// ----------------------------------------------------------------------------
// dipv4_back
// Runs the part parser on each token and holds the result for the sink.
// ----------------------------------------------------------------------------
module dipv4_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dipv4_pkg::token_t     head,
    input  dipv4_pkg::q_status_t  q_status,
    output logic                  pop,
    dipv4_result_if.source        result
);

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2,
        RADIX_ALT = 2'd3
    } radix_t;

    localparam int AW = dipv4_pkg::ADDR_W;

    logic [AW-1:0]   accum_reg, accum_next;
    logic [1:0]      part_count_reg, part_count_next;
    radix_t          radix_reg, radix_next;
    logic            have_digit_reg, have_digit_next;
    logic            lone_zero_reg, lone_zero_next;
    logic            failed_reg, failed_next;
    logic [7:0]      done_parts_reg [3];
    logic            store_part;
    logic            out_valid_reg, out_valid_next;
    logic            out_ok_reg;
    logic [AW-1:0]   out_addr_reg;

    logic            is_end;
    logic            fin_ok;
    logic [AW-1:0]   fin_addr;
    logic [AW+3:0]   scaled;
    logic [AW+3:0]   sum;
    logic            digit_ok;

    // Take a token unless it is the end of a string and the result slot is busy.
    assign is_end = (head.kind == dipv4_pkg::TOK_END);
    assign pop    = !q_status.empty && (!is_end || !out_valid_reg || result.ready);

    // Accumulator times base, plus the digit.
    always_comb
    begin
        unique case (radix_reg)
            RADIX_HEX: scaled = {accum_reg, 4'b0000};
            RADIX_OCT: scaled = {1'b0, accum_reg, 3'b000};
            default:   scaled = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0};
        endcase
        sum = scaled + (AW+4)'(head.value);
    end

    // Whether the digit or letter is valid in the part's base.
    always_comb
    begin
        unique case (radix_reg)
            RADIX_HEX: digit_ok = 1'b1;
            RADIX_OCT: digit_ok = (head.kind == dipv4_pkg::TOK_DIGIT) && (head.value < 4'd8);
            default:   digit_ok = (head.kind == dipv4_pkg::TOK_DIGIT);
        endcase
    end

    // Final check and packing of the address.
    always_comb
    begin
        fin_ok   = 1'b0;
        fin_addr = '0;
        if (!failed_reg && have_digit_reg)
        begin
            unique case (part_count_reg)
                2'd0:
                begin
                    fin_ok   = 1'b1;
                    fin_addr = accum_reg;
                end
                2'd1:
                begin
                    fin_ok   = (accum_reg[AW-1:24] == '0);
                    fin_addr = {done_parts_reg[0], accum_reg[23:0]};
                end
                2'd2:
                begin
                    fin_ok   = (accum_reg[AW-1:16] == '0);
                    fin_addr = {done_parts_reg[0], done_parts_reg[1], accum_reg[15:0]};
                end
                default:
                begin
                    fin_ok   = (accum_reg[AW-1:8] == '0);
                    fin_addr = {done_parts_reg[0], done_parts_reg[1], done_parts_reg[2],
                                accum_reg[7:0]};
                end
            endcase
        end
        if (!fin_ok)
        begin
            fin_addr = '0;
        end
    end

    // Parse step for the token at the head of the queue.
    always_comb
    begin
        accum_next      = accum_reg;
        part_count_next = part_count_reg;
        radix_next      = radix_reg;
        have_digit_next = have_digit_reg;
        lone_zero_next  = lone_zero_reg;
        failed_next     = failed_reg;
        store_part      = 1'b0;
        if (pop)
        begin
            if (is_end)
            begin
                accum_next      = '0;
                part_count_next = 2'd0;
                radix_next      = RADIX_DEC;
                have_digit_next = 1'b0;
                lone_zero_next  = 1'b0;
                failed_next     = 1'b0;
            end
            else if (!failed_reg)
            begin
                priority if (head.kind == dipv4_pkg::TOK_DOT)
                begin
                    if (!have_digit_reg || part_count_reg == 2'd3
                        || accum_reg[AW-1:8] != '0)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        store_part      = 1'b1;
                        part_count_next = part_count_reg + 1'b1;
                        accum_next      = '0;
                        radix_next      = RADIX_DEC;
                        have_digit_next = 1'b0;
                        lone_zero_next  = 1'b0;
                    end
                end
                else if (head.kind == dipv4_pkg::TOK_X)
                begin
                    if (lone_zero_reg)
                    begin
                        radix_next      = RADIX_HEX;
                        accum_next      = '0;
                        have_digit_next = 1'b0;
                        lone_zero_next  = 1'b0;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                else if (head.kind == dipv4_pkg::TOK_DIGIT && head.value == 4'd0
                         && !have_digit_reg && radix_reg == RADIX_DEC)
                begin
                    // A leading zero switches the part to octal.
                    radix_next      = RADIX_OCT;
                    accum_next      = '0;
                    have_digit_next = 1'b1;
                    lone_zero_next  = 1'b1;
                end
                else if ((head.kind == dipv4_pkg::TOK_DIGIT
                          || head.kind == dipv4_pkg::TOK_LETTER)
                         && digit_ok && sum[AW+3:AW] == '0)
                begin
                    accum_next      = sum[AW-1:0];
                    have_digit_next = 1'b1;
                    lone_zero_next  = 1'b0;
                end
                else
                begin
                    failed_next = 1'b1;
                end
            end
        end
    end

    // Result slot handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && is_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg      <= '0;
            part_count_reg <= 2'd0;
            radix_reg      <= RADIX_DEC;
            have_digit_reg <= 1'b0;
            lone_zero_reg  <= 1'b0;
            failed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            accum_reg      <= accum_next;
            part_count_reg <= part_count_next;
            radix_reg      <= radix_next;
            have_digit_reg <= have_digit_next;
            lone_zero_reg  <= lone_zero_next;
            failed_reg     <= failed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Completed parts and result payload
    always_ff @(posedge clk)
    begin
        if (store_part)
        begin
            done_parts_reg[part_count_reg] <= accum_reg[7:0];
        end
        if (pop && is_end)
        begin
            out_ok_reg   <= fin_ok;
            out_addr_reg <= fin_addr;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.ok    = out_ok_reg;
    assign result.addr  = out_addr_reg;

endmodule
